>>> hw/rtl/vbs_pkg.sv
// Shared constants, types and fixed-point helpers for the vertex skinning block.
package vbs_pkg;

  localparam int unsigned BONE_COUNT = 64;
  localparam int unsigned MAX_INF    = 4;
  localparam int unsigned BONE_W     = 6;
  localparam int unsigned ROWS       = 4;
  localparam int unsigned AXES       = 3;
  localparam int unsigned ONE_Q15    = 32768;
  localparam int unsigned W_W        = 19;  // signed weight, last one may go negative
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = $clog2(QDEPTH);
  localparam int unsigned BADDR_W    = $clog2(BONE_COUNT);
  localparam int unsigned ROW_BITS   = 32 * AXES;

  typedef enum logic [1:0] {
    FUNC_LOAD     = 2'd0,
    FUNC_SKIN     = 2'd1,
    FUNC_SKIN_END = 2'd2
  } func_e;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic                           is_load;
    logic                           batch_end;
    logic [1:0]                     last_inf;
    logic [1:0]                     row;
    logic [MAX_INF-1:0][BONE_W-1:0] bones;
    logic [MAX_INF-1:0][W_W-1:0]    w;
    word_t [AXES-1:0]               vec_a;
    word_t [AXES-1:0]               vec_b;
  } entry_t;

  typedef struct packed {
    logic           first;
    logic           last;
    logic           batch_end;
    logic [W_W-1:0] w;
  } ctl_t;

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

  function automatic word_t add_sat(input word_t a, input word_t b);
    logic signed [63:0] s;
    s = 64'(a) + 64'(b);
    return sat32(s);
  endfunction

  // Q16.16 x Q16.16, floored
  function automatic word_t mul_q16(input word_t a, input word_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> 16);
  endfunction

  // Q16.16 x signed Q4.15 weight, floored
  function automatic word_t mul_w(input word_t a, input logic signed [W_W-1:0] w);
    logic signed [63:0] p;
    p = 64'(a) * 64'(w);
    return sat32(p >>> 15);
  endfunction

endpackage

>>> hw/rtl/vbs_if.sv
// Valid/ready channel interfaces for vertex and result items.
interface vbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [1:0]  slot;
  logic [23:0] bone_ids;
  logic [15:0] weight0;
  logic [15:0] weight1;
  logic [15:0] weight2;
  logic signed [31:0] vec_a_x;
  logic signed [31:0] vec_a_y;
  logic signed [31:0] vec_a_z;
  logic signed [31:0] vec_b_x;
  logic signed [31:0] vec_b_y;
  logic signed [31:0] vec_b_z;
  modport source (output valid, func, slot, bone_ids, weight0, weight1, weight2,
                  vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, input ready);
  modport sink   (input valid, func, slot, bone_ids, weight0, weight1, weight2,
                  vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, output ready);
endinterface

interface vbs_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_pos_x;
  logic signed [31:0] out_pos_y;
  logic signed [31:0] out_pos_z;
  logic signed [31:0] out_nrm_x;
  logic signed [31:0] out_nrm_y;
  logic signed [31:0] out_nrm_z;
  logic        batch_end;
  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, batch_end, input ready);
  modport sink   (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, batch_end, output ready);
endinterface

>>> hw/rtl/vbs_front.sv
// Front end: decodes items, clamps bone ids, derives per-influence weights.
module vbs_front (
  vbs_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output vbs_pkg::entry_t entry_o
);

  logic                        keep;
  logic [vbs_pkg::BONE_W-1:0]  raw;
  logic [17:0]                 pre;
  logic [vbs_pkg::WIN_W-1:0]   win [vbs_pkg::MAX_INF];

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i && keep;

  always_comb begin
    win[0] = in_i.weight0;
    win[1] = in_i.weight1;
    win[2] = in_i.weight2;
    win[3] = '0;
    entry_o.is_load   = (in_i.func == vbs_pkg::FUNC_LOAD);
    entry_o.batch_end = (in_i.func == vbs_pkg::FUNC_SKIN_END);
    entry_o.row       = in_i.slot;
    entry_o.last_inf  = ({1'b0, in_i.slot} > 3'(vbs_pkg::MAX_INF - 1)) ?
                        2'(vbs_pkg::MAX_INF - 1) : in_i.slot;
    entry_o.vec_a     = {in_i.vec_a_z, in_i.vec_a_y, in_i.vec_a_x};
    entry_o.vec_b     = {in_i.vec_b_z, in_i.vec_b_y, in_i.vec_b_x};
    pre = '0;
    for (int k = 0; k < vbs_pkg::MAX_INF; k++) begin
      raw = in_i.bone_ids[k*vbs_pkg::BONE_W +: vbs_pkg::BONE_W];
      entry_o.bones[k] = ({1'b0, raw} >= 7'(vbs_pkg::BONE_COUNT)) ?
                         6'(vbs_pkg::BONE_COUNT - 1) : raw;
      if (2'(k) < entry_o.last_inf) begin
        entry_o.w[k] = 19'(win[k]);
      end else if (2'(k) == entry_o.last_inf) begin
        entry_o.w[k] = 19'(vbs_pkg::ONE_Q15) - {1'b0, pre};
      end else begin
        entry_o.w[k] = '0;
      end
      pre = pre + 18'(win[k]);
    end
    raw = in_i.bone_ids[vbs_pkg::BONE_W-1:0];
    unique case (in_i.func)
      vbs_pkg::FUNC_LOAD:     keep = ({1'b0, raw} < 7'(vbs_pkg::BONE_COUNT));
      vbs_pkg::FUNC_SKIN,
      vbs_pkg::FUNC_SKIN_END: keep = 1'b1;
      default:                keep = 1'b0;  // unused code, dropped
    endcase
  end

endmodule

>>> hw/rtl/vbs_fifo.sv
// Short queue of decoded items between front and back end.
module vbs_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vbs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output vbs_pkg::entry_t head_o
);

  vbs_pkg::entry_t                 slot_q [vbs_pkg::QDEPTH];
  logic [vbs_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [vbs_pkg::QPTR_W:0]        cnt_q, cnt_d;

  assign full_o  = (cnt_q == (vbs_pkg::QPTR_W+1)'(vbs_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];
  assign cnt_d   = cnt_q + (vbs_pkg::QPTR_W+1)'(push_i) - (vbs_pkg::QPTR_W+1)'(pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= entry_i;
  end

endmodule

>>> hw/rtl/vbs_back.sv
// Back end: palette memory, influence sequencer and skinning pipeline.
module vbs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  vbs_pkg::entry_t head_i,
  output logic            pop_o,
  vbs_out_if.source       out_o
);

  logic [vbs_pkg::ROW_BITS-1:0] pal_q [vbs_pkg::ROWS][vbs_pkg::BONE_COUNT];
  logic [vbs_pkg::ROW_BITS-1:0] rd_q  [vbs_pkg::ROWS];

  logic       en, issue, wr_en;
  logic [1:0] inf_q;
  logic [vbs_pkg::BADDR_W-1:0] addr;

  logic                             v1_q, v2_q, v3_q, v4_q;
  vbs_pkg::ctl_t                    c1_q, c2_q, c3_q, c4_q;
  vbs_pkg::word_t [vbs_pkg::AXES-1:0] a1_q, b1_q;
  vbs_pkg::word_t                   pp_q [vbs_pkg::AXES][vbs_pkg::AXES];
  vbs_pkg::word_t                   np_q [vbs_pkg::AXES][vbs_pkg::AXES];
  vbs_pkg::word_t                   tr_q [vbs_pkg::AXES];
  vbs_pkg::word_t                   tp_q [vbs_pkg::AXES];
  vbs_pkg::word_t                   tn_q [vbs_pkg::AXES];
  vbs_pkg::word_t                   mp_q [vbs_pkg::AXES];
  vbs_pkg::word_t                   mn_q [vbs_pkg::AXES];
  vbs_pkg::word_t                   accp_q [vbs_pkg::AXES], accn_q [vbs_pkg::AXES];
  vbs_pkg::word_t                   sump [vbs_pkg::AXES], sumn [vbs_pkg::AXES];
  vbs_pkg::word_t                   outp_q [vbs_pkg::AXES], outn_q [vbs_pkg::AXES];
  logic                             ov_q, obe_q;

  // whole pipeline holds while a result waits
  assign en    = !ov_q || out_o.ready;
  assign wr_en = en && head_valid_i && head_i.is_load;
  assign issue = en && head_valid_i && !head_i.is_load;
  assign pop_o = en && head_valid_i && (head_i.is_load || inf_q == head_i.last_inf);
  assign addr  = head_i.is_load ? head_i.bones[0] : head_i.bones[inf_q];

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < vbs_pkg::ROWS; r++) begin
      if (wr_en && head_i.row == 2'(r)) pal_q[r][addr] <= head_i.vec_a;
      if (issue) rd_q[r] <= pal_q[r][addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inf_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (pop_o)      inf_q <= '0;
      else if (issue) inf_q <= inf_q + 1'b1;
      if (en) begin
        v1_q <= issue;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
      end
      ov_q <= (ov_q && !out_o.ready) || (en && v4_q && c4_q.last);
    end
  end

  always_comb begin
    for (int a = 0; a < vbs_pkg::AXES; a++) begin
      sump[a] = c4_q.first ? mp_q[a] : vbs_pkg::add_sat(accp_q[a], mp_q[a]);
      sumn[a] = c4_q.first ? mn_q[a] : vbs_pkg::add_sat(accn_q[a], mn_q[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // issue stage
      c1_q.first     <= (inf_q == 2'd0);
      c1_q.last      <= (inf_q == head_i.last_inf);
      c1_q.batch_end <= head_i.batch_end;
      c1_q.w         <= head_i.w[inf_q];
      a1_q           <= head_i.vec_a;
      b1_q           <= head_i.vec_b;
      // row products
      c2_q <= c1_q;
      for (int a = 0; a < vbs_pkg::AXES; a++) begin
        tr_q[a] <= rd_q[3][32*a +: 32];
        for (int r = 0; r < vbs_pkg::AXES; r++) begin
          pp_q[a][r] <= vbs_pkg::mul_q16(a1_q[r], rd_q[r][32*a +: 32]);
          np_q[a][r] <= vbs_pkg::mul_q16(b1_q[r], rd_q[r][32*a +: 32]);
        end
      end
      // row sums, translation on the position
      c3_q <= c2_q;
      for (int a = 0; a < vbs_pkg::AXES; a++) begin
        tp_q[a] <= vbs_pkg::add_sat(vbs_pkg::add_sat(vbs_pkg::add_sat(
                     pp_q[a][0], pp_q[a][1]), pp_q[a][2]), tr_q[a]);
        tn_q[a] <= vbs_pkg::add_sat(vbs_pkg::add_sat(np_q[a][0], np_q[a][1]), np_q[a][2]);
      end
      // weighting
      c4_q <= c3_q;
      for (int a = 0; a < vbs_pkg::AXES; a++) begin
        mp_q[a] <= vbs_pkg::mul_w(tp_q[a], c3_q.w);
        mn_q[a] <= vbs_pkg::mul_w(tn_q[a], c3_q.w);
      end
      // accumulate in influence order
      if (v4_q) begin
        for (int a = 0; a < vbs_pkg::AXES; a++) begin
          accp_q[a] <= sump[a];
          accn_q[a] <= sumn[a];
          if (c4_q.last) begin
            outp_q[a] <= sump[a];
            outn_q[a] <= sumn[a];
          end
        end
        if (c4_q.last) obe_q <= c4_q.batch_end;
      end
    end
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_pos_x = outp_q[0];
  assign out_o.out_pos_y = outp_q[1];
  assign out_o.out_pos_z = outp_q[2];
  assign out_o.out_nrm_x = outn_q[0];
  assign out_o.out_nrm_y = outn_q[1];
  assign out_o.out_nrm_z = outn_q[2];
  assign out_o.batch_end = obe_q;

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i) else $error("pop without queued item");
  a_idle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> inf_q == 2'd0) else $error("influence count left over");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v4_q)) else $error("pipeline moved during stall");
  a_no_wr_and_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en && issue)) else $error("palette write and read together");

endmodule

>>> hw/rtl/vertex_bone_skinning_top.sv
// Top level of the four-influence linear blend skinning block.
//
//  channel | dir | handshake   | items
//  in_i    | in  | valid/ready | bone row loads, vertices
//  out_o   | out | valid/ready | skinned position and normal, one per vertex
//
// The back end takes one load or one vertex influence per cycle while no result
// waits at the output (1 to 4 influences per vertex), set by the single read port
// of the palette memory per row. A result passes the issue, row-product, row-sum,
// weighting and accumulate registers before it shows. Input is taken while the
// four-entry queue has room. Reset clears control only; palette rows are
// undefined until loaded. A stalled result holds the back end, not the front.
module vertex_bone_skinning_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  vbs_in_if.sink    in_i,
  vbs_out_if.source out_o
);

  logic            push, full, pop, head_valid;
  vbs_pkg::entry_t entry, head;

  vbs_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  vbs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head)
  );

  vbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

>>> sim/tb.sv
// Self-checking testbench for the four-influence vertex skinning block.
module tb;
  import vbs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned N_RANDOM   = 450;
  localparam int unsigned N_QUIET    = 60;
  localparam word_t       Q_ONE      = 32'sh0001_0000;

  typedef struct packed {
    logic [1:0]  func;
    logic [1:0]  slot;
    logic [23:0] ids;
    logic [15:0] w0, w1, w2;
    word_t       ax, ay, az, bx, by, bz;
  } vtx_item_t;

  typedef struct packed {
    word_t px, py, pz, nx, ny, nz;
    logic  be;
  } skin_res_t;

  typedef struct packed {
    vtx_item_t it;
    logic      fixed;
    skin_res_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  vbs_in_if  in_ch();
  vbs_out_if out_ch();

  vertex_bone_skinning_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // shadow palette and row-written flags
  word_t     pal_m [BONE_COUNT][ROWS][AXES];
  logic [3:0] rows_seen [BONE_COUNT];
  int unsigned bones_ready [$];

  skin_res_t pending_res [$];
  stim_row_t stim_q [$];
  int unsigned errors = 0;
  logic quiet = 1'b0;
  logic sending_done = 1'b0;

  function automatic word_t clip(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic skin_res_t skin_vertex(input vtx_item_t it);
    skin_res_t r;
    logic signed [63:0] pv [3];
    logic signed [63:0] nv [3];
    logic signed [63:0] win [3];
    logic signed [63:0] w, wsum, tp, tn;
    word_t psum [3];
    word_t nsum [3];
    int unsigned cnt, bone;
    pv[0] = it.ax; pv[1] = it.ay; pv[2] = it.az;
    nv[0] = it.bx; nv[1] = it.by; nv[2] = it.bz;
    win[0] = {48'd0, it.w0}; win[1] = {48'd0, it.w1}; win[2] = {48'd0, it.w2};
    cnt = it.slot + 1;
    if (cnt > MAX_INF) cnt = MAX_INF;
    wsum = 0;
    for (int a = 0; a < 3; a++) begin
      psum[a] = '0;
      nsum[a] = '0;
    end
    for (int k = 0; k < cnt; k++) begin
      bone = it.ids[6*k +: 6];
      if (bone >= BONE_COUNT) bone = BONE_COUNT - 1;
      if (k + 1 == cnt) begin
        w = 64'sd32768 - wsum;
      end else begin
        w = win[k];
        wsum += w;
      end
      for (int a = 0; a < 3; a++) begin
        tp = 0;
        tn = 0;
        for (int row = 0; row < 3; row++) begin
          tp = clip(tp + clip((pv[row] * 64'(pal_m[bone][row][a])) >>> 16));
          tn = clip(tn + clip((nv[row] * 64'(pal_m[bone][row][a])) >>> 16));
        end
        tp = clip(tp + 64'(pal_m[bone][3][a]));
        psum[a] = clip(64'(psum[a]) + 64'(clip((tp * w) >>> 15)));
        nsum[a] = clip(64'(nsum[a]) + 64'(clip((tn * w) >>> 15)));
      end
    end
    r.px = psum[0]; r.py = psum[1]; r.pz = psum[2];
    r.nx = nsum[0]; r.ny = nsum[1]; r.nz = nsum[2];
    r.be = (it.func == FUNC_SKIN_END);
    return r;
  endfunction

  // state update and expectation for one accepted item
  task automatic take_item(input stim_row_t row);
    int unsigned bone;
    if (row.it.func == FUNC_LOAD) begin
      bone = row.it.ids[5:0];
      pal_m[bone][row.it.slot][0] = row.it.ax;
      pal_m[bone][row.it.slot][1] = row.it.ay;
      pal_m[bone][row.it.slot][2] = row.it.az;
      if (rows_seen[bone] != 4'hf) begin
        rows_seen[bone][row.it.slot] = 1'b1;
        if (rows_seen[bone] == 4'hf) bones_ready.push_back(bone);
      end
    end else if (row.it.func != FUNC_UNUSED) begin
      pending_res.push_back(row.fixed ? row.res : skin_vertex(row.it));
    end
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      3: return $urandom;
      default: return word_t'($signed($urandom_range(0, 32'h80000))) - 32'sh40000;
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 16384));
    endcase
  endfunction

  function automatic vtx_item_t load_item(input int unsigned bone, input int unsigned row,
                                          input word_t x, input word_t y, input word_t z);
    vtx_item_t it;
    it.ids = 24'($urandom);
    it.w0 = 16'($urandom); it.w1 = 16'($urandom); it.w2 = 16'($urandom);
    it.bx = $urandom; it.by = $urandom; it.bz = $urandom;
    it.func = FUNC_LOAD;
    it.slot = 2'(row);
    it.ids  = {it.ids[23:6], 6'(bone)};
    it.ax = x; it.ay = y; it.az = z;
    return it;
  endfunction

  function automatic vtx_item_t vertex_item(input logic [1:0] fn, input logic [1:0] slot,
                                            input logic [23:0] ids);
    vtx_item_t it;
    it.func = fn;
    it.slot = slot;
    it.ids  = ids;
    it.w0 = rand_weight(); it.w1 = rand_weight(); it.w2 = rand_weight();
    it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
    it.bx = rand_word(); it.by = rand_word(); it.bz = rand_word();
    return it;
  endfunction

  task automatic add_row(input vtx_item_t it);
    stim_row_t r;
    r.it = it;
    r.fixed = 1'b0;
    r.res = '0;
    stim_q.push_back(r);
  endtask

  task automatic add_fixed(input vtx_item_t it, input skin_res_t res);
    stim_row_t r;
    r.it = it;
    r.fixed = 1'b1;
    r.res = res;
    stim_q.push_back(r);
  endtask

  task automatic build_directed();
    vtx_item_t it;
    skin_res_t res;
    // bone 0: identity with translation (5, -3, 0)
    add_row(load_item(0, 0, Q_ONE, 0, 0));
    add_row(load_item(0, 1, 0, Q_ONE, 0));
    add_row(load_item(0, 2, 0, 0, Q_ONE));
    add_row(load_item(0, 3, 5 * Q_ONE, -3 * Q_ONE, 0));
    // bone 63 at the extremes, upper id bits all set on its first row
    it = load_item(63, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    it.ids = 24'hffffff;
    add_row(it);
    add_row(load_item(63, 1, 32'sh80000000, 32'sh7fffffff, 32'sh80000000));
    add_row(load_item(63, 2, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
    add_row(load_item(63, 3, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    // bone 1: negated identity
    add_row(load_item(1, 0, -Q_ONE, 0, 0));
    add_row(load_item(1, 1, 0, -Q_ONE, 0));
    add_row(load_item(1, 2, 0, 0, -Q_ONE));
    add_row(load_item(1, 3, 0, 0, 0));
    // unused func code over bone 0 must leave it alone
    it = load_item(0, 3, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    it.func = FUNC_UNUSED;
    add_row(it);
    // single influence through bone 0: weight is exactly one
    it = vertex_item(FUNC_SKIN, 2'd0, 24'hfff000);
    it.w0 = 16'hffff; it.w1 = 16'hffff; it.w2 = 16'hffff;
    it.ax = Q_ONE; it.ay = 2 * Q_ONE; it.az = 3 * Q_ONE;
    it.bx = 32'sh7fffffff; it.by = 32'sh80000000; it.bz = 0;
    res = '{px: 6 * Q_ONE, py: -Q_ONE, pz: 3 * Q_ONE,
            nx: 32'sh7fffffff, ny: 32'sh80000000, nz: 0, be: 1'b0};
    add_fixed(it, res);
    it.func = FUNC_SKIN_END;
    res.be = 1'b1;
    add_fixed(it, res);
    // extremes through bone 63
    it = vertex_item(FUNC_SKIN, 2'd0, 24'h00003f);
    it.ax = 32'sh80000000; it.ay = 32'sh80000000; it.az = 32'sh80000000;
    it.bx = 32'sh80000000; it.by = 32'sh7fffffff; it.bz = 32'sh80000000;
    add_row(it);
    // four influences, zero explicit weights: last one carries all
    it = vertex_item(FUNC_SKIN, 2'd3, {6'd0, 6'd63, 6'd1, 6'd0});
    it.w0 = 0; it.w1 = 0; it.w2 = 0;
    add_row(it);
    // heavy explicit weights drive the last weight negative
    it = vertex_item(FUNC_SKIN_END, 2'd3, {6'd1, 6'd63, 6'd1, 6'd0});
    it.w0 = 16'hffff; it.w1 = 16'hffff; it.w2 = 16'hffff;
    add_row(it);
    it = vertex_item(FUNC_SKIN, 2'd1, {12'hace, 6'd1, 6'd0});
    it.w0 = 16'd16384;
    add_row(it);
    it = vertex_item(FUNC_SKIN, 2'd2, {6'h2a, 6'd0, 6'd63, 6'd1});
    it.w0 = 16'd32768; it.w1 = 16'd32768;
    add_row(it);
    it = vertex_item(FUNC_SKIN_END, 2'd2, {6'h15, 6'd63, 6'd0, 6'd63});
    add_row(it);
  endtask

  // random part, generated as it goes so vertices see the bones loaded so far
  function automatic vtx_item_t rand_vertex();
    vtx_item_t it;
    logic [23:0] ids;
    logic [1:0] slot;
    ids = 24'($urandom);
    slot = 2'($urandom_range(0, 3));
    for (int k = 0; k <= slot; k++)
      ids[6*k +: 6] = 6'(bones_ready[$urandom_range(0, bones_ready.size() - 1)]);
    it = vertex_item($urandom_range(0, 3) == 0 ? FUNC_SKIN_END : FUNC_SKIN, slot, ids);
    return it;
  endfunction

  task automatic send_row(input stim_row_t row);
    in_ch.func     <= row.it.func;
    in_ch.slot     <= row.it.slot;
    in_ch.bone_ids <= row.it.ids;
    in_ch.weight0  <= row.it.w0;
    in_ch.weight1  <= row.it.w1;
    in_ch.weight2  <= row.it.w2;
    in_ch.vec_a_x  <= row.it.ax;
    in_ch.vec_a_y  <= row.it.ay;
    in_ch.vec_a_z  <= row.it.az;
    in_ch.vec_b_x  <= row.it.bx;
    in_ch.vec_b_y  <= row.it.by;
    in_ch.vec_b_z  <= row.it.bz;
    in_ch.valid    <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    take_item(row);
    // optional idle burst before the next item
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input word_t exp, input word_t act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      errors++;
    end
  endtask

  // result side: check at each accepted result, then pick next ready
  int unsigned out_stall = 0;
  always @(posedge clk) begin
    skin_res_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with no expectation waiting", $time);
        errors++;
      end else begin
        e = pending_res.pop_front();
        check_field("pos_x", e.px, out_ch.out_pos_x);
        check_field("pos_y", e.py, out_ch.out_pos_y);
        check_field("pos_z", e.pz, out_ch.out_pos_z);
        check_field("nrm_x", e.nx, out_ch.out_nrm_x);
        check_field("nrm_y", e.ny, out_ch.out_nrm_y);
        check_field("nrm_z", e.nz, out_ch.out_nrm_z);
        if (e.be !== out_ch.batch_end) begin
          $display("%0t: batch_end mismatch, expected %b, got %b", $time, e.be,
                   out_ch.batch_end);
          errors++;
        end
      end
    end
    if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      out_stall = $urandom_range(0, 2);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted item
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else if (rst_n)
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned bone;
    stim_row_t row;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_LOAD;
    in_ch.slot = '0;
    in_ch.bone_ids = '0;
    in_ch.weight0 = '0;
    in_ch.weight1 = '0;
    in_ch.weight2 = '0;
    in_ch.vec_a_x = '0;
    in_ch.vec_a_y = '0;
    in_ch.vec_a_z = '0;
    in_ch.vec_b_x = '0;
    in_ch.vec_b_y = '0;
    in_ch.vec_b_z = '0;
    out_ch.ready = 1'b0;
    for (int b = 0; b < BONE_COUNT; b++) rows_seen[b] = 4'h0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    while (stim_q.size() > 0) send_row(stim_q.pop_front());

    // random: mostly vertices over loaded bones, plus whole-bone load bursts
    // and stray single-row loads
    sent = 0;
    while (sent < N_RANDOM) begin
      if (sent >= N_RANDOM - N_QUIET) quiet = 1'b1;
      row.fixed = 1'b0;
      row.res = '0;
      case ($urandom_range(0, 9))
        0, 1: begin
          bone = $urandom_range(0, BONE_COUNT - 1);
          for (int r = 0; r < ROWS; r++) begin
            row.it = load_item(bone, r, rand_word(), rand_word(), rand_word());
            send_row(row);
          end
          sent += ROWS;
        end
        2: begin
          row.it = load_item($urandom_range(0, BONE_COUNT - 1), $urandom_range(0, 3),
                             rand_word(), rand_word(), rand_word());
          if ($urandom_range(0, 3) == 0) row.it.func = FUNC_UNUSED;
          send_row(row);
          sent++;
        end
        default: begin
          row.it = rand_vertex();
          send_row(row);
          sent++;
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    while (pending_res.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
